@@ hw/rtl/one_wire_bus_master_assert.svh @@
// Assertion macros used by the checker file of the bus master.
// Each macro takes a label, a clock, a disable condition, an antecedent,
// a consequent and a message.
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OWBM_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OWBM_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/owbm_pkg.sv @@
// ---------------------------------------------------------------------------
// owbm_pkg
// Types and constants shared by the 1-Wire bus master modules.
// ---------------------------------------------------------------------------
package owbm_pkg;

    // Timer width default and the fixed strong-high recovery length.
    localparam int TIMER_WIDTH_DEF = 10;
    localparam int RECOVERY_TICKS  = 5;

    // Depth of the queues between the ports and the sequencer.
    localparam int QUEUE_DEPTH = 2;

    // Configuration registers.
    localparam int CFG_NUM    = 8;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_PORT_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_WAIT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL     = 3'd7;

    localparam logic [CFG_W-1:0] CFG_RESET_VAL [CFG_NUM] = '{
        10'd600, 10'd80, 10'd600, 10'd5, 10'd60, 10'd10, 10'd10, 10'd40
    };

    // Input mode codes.
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_RESET   = 3'd1;
    localparam logic [2:0] MODE_WR_BYTE = 3'd2;
    localparam logic [2:0] MODE_RD_BYTE = 3'd3;
    localparam logic [2:0] MODE_WR_BIT  = 3'd4;
    localparam logic [2:0] MODE_RD_BIT  = 3'd5;

    // Classified command codes handed from the front to the back.
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_RESET   = 3'd1;
    localparam logic [2:0] CMD_WR_BYTE = 3'd2;
    localparam logic [2:0] CMD_RD_BYTE = 3'd3;
    localparam logic [2:0] CMD_WR_BIT  = 3'd4;
    localparam logic [2:0] CMD_RD_BIT  = 3'd5;

    // Line drive codes.
    localparam logic [1:0] DRV_REL  = 2'd0;
    localparam logic [1:0] DRV_LOW  = 2'd1;
    localparam logic [1:0] DRV_HIGH = 2'd2;

    // Bus reset outcomes.
    localparam logic [1:0] STS_PRESENT   = 2'd0;
    localparam logic [1:0] STS_NO_DEVICE = 2'd1;
    localparam logic [1:0] STS_STUCK_LOW = 2'd2;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic       line_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0] line_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic [1:0] reset_status;
    } t_out_item;

    // One classified tick waiting for the sequencer.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic       line_in;
    } t_tick;

endpackage

@@ hw/rtl/owbm_front.sv @@
// ---------------------------------------------------------------------------
// owbm_front
// Accepts tick beats, classifies the mode into a command and holds the
// classified ticks in a short queue for the sequencer.
// ---------------------------------------------------------------------------
module owbm_front #(
    parameter int DEPTH = owbm_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  owbm_pkg::t_in_item i_in,
    output logic              o_full,
    output logic              o_tick_valid,
    output owbm_pkg::t_tick   o_tick,
    input  logic              i_tick_take
);
    import owbm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_tick           r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic            push_ok;
    logic            take_ok;
    t_tick           cls;

    assign o_full       = (r_cnt == CW'(DEPTH));
    assign o_tick_valid = (r_cnt != '0);
    assign o_tick       = r_mem[r_rd];
    assign push_ok      = i_push && !o_full;
    assign take_ok      = i_tick_take && o_tick_valid;

    // Unused modes are plain ticks.
    always_comb begin
        cls.data_byte = i_in.data_byte;
        cls.line_in   = i_in.line_in;
        if (i_in.mode inside {[MODE_RESET:MODE_RD_BIT]}) begin
            case (i_in.mode)
                MODE_RESET:   cls.cmd = CMD_RESET;
                MODE_WR_BYTE: cls.cmd = CMD_WR_BYTE;
                MODE_RD_BYTE: cls.cmd = CMD_RD_BYTE;
                MODE_WR_BIT:  cls.cmd = CMD_WR_BIT;
                default:      cls.cmd = CMD_RD_BIT;
            endcase
        end else begin
            cls.cmd = CMD_NONE;
        end
    end

    // Occupancy count.
    always_comb begin
        case ({push_ok, take_ok})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    // Queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push_ok) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (take_ok) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= cls;
        end
    end

endmodule

@@ hw/rtl/owbm_back.sv @@
// ---------------------------------------------------------------------------
// owbm_back
// Slot sequencer: advances one classified tick per cycle while the result queue has room,
// times each phase from the timing registers and queues one result beat per tick.
// ---------------------------------------------------------------------------
module owbm_back #(
    parameter int TW    = owbm_pkg::TIMER_WIDTH_DEF,
    parameter int DEPTH = owbm_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [owbm_pkg::CFG_PORT_W-1:0]    i_cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                               o_cfg_ready,
    input  logic                               i_tick_valid,
    input  owbm_pkg::t_tick                    i_tick,
    output logic                               o_tick_take,
    input  logic                               i_pop,
    output logic                               o_empty,
    output owbm_pkg::t_out_item                o_out
);
    import owbm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (TW > CFG_W) ? TW : CFG_W;
    localparam logic [LW-1:0] MAXV = LW'({TW{1'b1}});

    // Phase codes.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_WR_LOW   = 4'd4;
    localparam logic [3:0] PH_WR_SLOT  = 4'd5;
    localparam logic [3:0] PH_WR_REC   = 4'd6;
    localparam logic [3:0] PH_RD_LOW   = 4'd7;
    localparam logic [3:0] PH_RD_WAIT  = 4'd8;
    localparam logic [3:0] PH_RD_TAIL  = 4'd9;

    localparam logic [2:0] BIT_LAST = 3'd7;

    logic [CFG_W-1:0] r_cfg [CFG_NUM];

    logic [3:0]    r_phase,    n_phase;
    logic [TW-1:0] r_timer,    n_timer;
    logic [2:0]    r_bit,      n_bit;
    logic [7:0]    r_shift,    n_shift;
    logic          r_multi,    n_multi;
    logic          r_presence, n_presence;
    logic [1:0]    r_status,   n_status;
    logic [7:0]    r_rdata,    n_rdata;

    t_out_item     res;
    t_out_item     r_oq [DEPTH];
    logic [PW-1:0] r_owr;
    logic [PW-1:0] r_ord;
    logic [CW-1:0] r_ocnt;
    logic [CW-1:0] n_ocnt;
    logic          fire;
    logic          pop_ok;

    // Timer load for a phase: zero counts as one tick, long values saturate.
    function automatic logic [TW-1:0] load_of(input logic [3:0] ph);
        logic [CFG_W-1:0] d;
        logic [LW-1:0]    e;
        case (ph)
            PH_RST_LOW:  d = r_cfg[CFG_RESET_LOW];
            PH_RST_WAIT: d = r_cfg[CFG_PRESENCE_WAIT];
            PH_RST_TAIL: d = r_cfg[CFG_RESET_TAIL];
            PH_WR_LOW:   d = r_cfg[CFG_WRITE_LOW];
            PH_WR_SLOT:  d = r_cfg[CFG_WRITE_SLOT];
            PH_WR_REC:   d = CFG_W'(RECOVERY_TICKS);
            PH_RD_LOW:   d = r_cfg[CFG_READ_LOW];
            PH_RD_WAIT:  d = r_cfg[CFG_READ_WAIT];
            default:     d = r_cfg[CFG_READ_TAIL];
        endcase
        e = LW'(d);
        if (e > MAXV) begin
            e = MAXV;
        end
        if (e == '0) begin
            e = LW'(1);
        end
        return TW'(e - LW'(1));
    endfunction

    // Configuration writes; indexes past the register list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= CFG_RESET_VAL[i];
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_PORT_W'(CFG_NUM))) begin
            r_cfg[i_cfg_index[CFG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // A tick is processed whenever the result queue can take its beat.
    assign o_empty     = (r_ocnt == '0);
    assign pop_ok      = i_pop && !o_empty;
    assign fire        = i_tick_valid && ((r_ocnt != CW'(DEPTH)) || pop_ok);
    assign o_tick_take = fire;
    assign o_out       = r_oq[r_ord];

    // Sequencer: command start, drive level, phase countdown and transitions.
    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_multi    = r_multi;
        n_presence = r_presence;
        n_status   = r_status;
        n_rdata    = r_rdata;
        res        = '0;

        // Start a command on the tick it arrives.
        if (r_phase == PH_IDLE && i_tick.cmd != CMD_NONE) begin
            n_bit   = '0;
            n_multi = (i_tick.cmd == CMD_WR_BYTE) || (i_tick.cmd == CMD_RD_BYTE);
            n_shift = (i_tick.cmd == CMD_WR_BIT) ? {7'd0, i_tick.data_byte[0]}
                                                 : i_tick.data_byte;
            case (i_tick.cmd)
                CMD_RESET: begin
                    n_phase = PH_RST_LOW;
                end
                CMD_WR_BYTE, CMD_WR_BIT: begin
                    n_phase = PH_WR_LOW;
                end
                default: begin
                    n_shift = '0;
                    n_phase = PH_RD_LOW;
                end
            endcase
            n_timer = load_of(n_phase);
        end

        if (n_phase != PH_IDLE) begin
            res.busy_res = 1'b1;
            case (n_phase)
                PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: res.line_drive = DRV_LOW;
                PH_WR_SLOT: res.line_drive = n_shift[0] ? DRV_REL : DRV_LOW;
                PH_WR_REC:  res.line_drive = DRV_HIGH;
                default:    res.line_drive = DRV_REL;
            endcase

            if (n_timer != '0) begin
                n_timer = n_timer - TW'(1);
            end else begin
                case (n_phase)
                    PH_RST_LOW: begin
                        n_phase = PH_RST_WAIT;
                        n_timer = load_of(PH_RST_WAIT);
                    end
                    PH_RST_WAIT: begin
                        n_presence = i_tick.line_in;
                        n_phase    = PH_RST_TAIL;
                        n_timer    = load_of(PH_RST_TAIL);
                    end
                    PH_RST_TAIL: begin
                        n_status     = i_tick.line_in ? {1'b0, n_presence} : STS_STUCK_LOW;
                        n_phase      = PH_IDLE;
                        res.done_res = 1'b1;
                    end
                    PH_WR_LOW: begin
                        n_phase = PH_WR_SLOT;
                        n_timer = load_of(PH_WR_SLOT);
                    end
                    PH_WR_SLOT: begin
                        n_phase = PH_WR_REC;
                        n_timer = load_of(PH_WR_REC);
                    end
                    PH_WR_REC: begin
                        n_shift = {1'b0, n_shift[7:1]};
                        if (n_multi && n_bit != BIT_LAST) begin
                            n_bit   = n_bit + 3'd1;
                            n_phase = PH_WR_LOW;
                            n_timer = load_of(PH_WR_LOW);
                        end else begin
                            n_phase      = PH_IDLE;
                            n_timer      = '0;
                            res.done_res = 1'b1;
                        end
                    end
                    PH_RD_LOW: begin
                        n_phase = PH_RD_WAIT;
                        n_timer = load_of(PH_RD_WAIT);
                    end
                    PH_RD_WAIT: begin
                        n_shift = n_multi ? {i_tick.line_in, n_shift[7:1]}
                                          : {7'd0, i_tick.line_in};
                        n_phase = PH_RD_TAIL;
                        n_timer = load_of(PH_RD_TAIL);
                    end
                    default: begin
                        if (n_multi && n_bit != BIT_LAST) begin
                            n_bit   = n_bit + 3'd1;
                            n_phase = PH_RD_LOW;
                            n_timer = load_of(PH_RD_LOW);
                        end else begin
                            n_phase      = PH_IDLE;
                            n_timer      = '0;
                            n_rdata      = n_shift;
                            res.done_res = 1'b1;
                        end
                    end
                endcase
            end
        end

        res.read_data    = n_rdata;
        res.reset_status = n_status;
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_multi    <= 1'b0;
            r_presence <= 1'b1;
            r_status   <= STS_NO_DEVICE;
            r_rdata    <= '0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_multi    <= n_multi;
            r_presence <= n_presence;
            r_status   <= n_status;
            r_rdata    <= n_rdata;
        end
    end

    // Result queue count.
    always_comb begin
        case ({fire, pop_ok})
            2'b10:   n_ocnt = r_ocnt + CW'(1);
            2'b01:   n_ocnt = r_ocnt - CW'(1);
            default: n_ocnt = r_ocnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            r_ocnt <= n_ocnt;
            if (fire) begin
                r_owr <= (r_owr == PW'(DEPTH - 1)) ? '0 : r_owr + PW'(1);
            end
            if (pop_ok) begin
                r_ord <= (r_ord == PW'(DEPTH - 1)) ? '0 : r_ord + PW'(1);
            end
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_oq[r_owr] <= res;
        end
    end

endmodule

@@ hw/rtl/one_wire_bus_master.sv @@
// Path: a tick beat is written into the front queue, taken from there by the sequencer
// into the result queue and popped from that queue; a full result queue holds it back.
// Throughput: one tick per cycle while the result queue has room.
// Queues of two beats on each side let push and pop stall independently.
// Reset (synchronous, active low) empties both queues, returns the sequencer
// to idle and reloads the default slot timings.
// ---------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master driven by a microsecond tick stream: a classifying
// front queue feeds the slot sequencer, which queues one result per tick.
// ---------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF,
    parameter int QUEUE_DEPTH = owbm_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [owbm_pkg::CFG_PORT_W-1:0] i_cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                            o_cfg_ready,
    input  logic                            i_push,
    input  owbm_pkg::t_in_item              i_in,
    output logic                            o_full,
    input  logic                            i_pop,
    output logic                            o_empty,
    output owbm_pkg::t_out_item             o_out
);
    import owbm_pkg::*;

    t_tick tick;
    logic  tick_valid;
    logic  tick_take;

    // Front: accept and classify tick beats.
    owbm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_in         (i_in),
        .o_full       (o_full),
        .o_tick_valid (tick_valid),
        .o_tick       (tick),
        .i_tick_take  (tick_take)
    );

    // Back: slot sequencing and result queue.
    owbm_back #(
        .TW    (TIMER_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_tick_valid (tick_valid),
        .i_tick       (tick),
        .o_tick_take  (tick_take),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_out        (o_out)
    );

endmodule

@@ hw/rtl/owbm_checker.sv @@
// ---------------------------------------------------------------------------
// owbm_checker
// Port-level checks on the bus master, bound to the top level.
// ---------------------------------------------------------------------------
`include "one_wire_bus_master_assert.svh"

module owbm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_full,
    input logic                i_pop,
    input logic                o_empty,
    input owbm_pkg::t_out_item o_out
);
    import owbm_pkg::*;

    // Both queues come out of reset empty.
    `OWBM_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, o_empty && !o_full, "queues not empty after reset")

    // A tick with no command in progress leaves the line released.
    `OWBM_ASSERT_NOW(a_idle_released, i_clk, !i_rst_n, !o_empty && !o_out.busy_res, o_out.line_drive == DRV_REL, "line driven while idle")

    // Completion is only reported on a tick that a command occupies.
    `OWBM_ASSERT_NOW(a_done_busy, i_clk, !i_rst_n, !o_empty && o_out.done_res, o_out.busy_res, "done without busy")

    // A waiting result beat holds until it is taken.
    `OWBM_ASSERT_NEXT(a_hold_result, i_clk, !i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_out), "result beat changed while stalled")

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_full  (o_full),
    .i_pop   (i_pop),
    .o_empty (o_empty),
    .o_out   (o_out)
);

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 1-Wire bus master. Microsecond tick beats go
// in through the push side and one result beat per tick comes back on the
// pop side. Each result beat is compared, field by field, with a cycle
// model of the slot sequencer that runs alongside it. The first rows of a
// table of directed commands run at the reset timings, the rest at the
// shortest slots. Short random command streams then run under a few more
// timing settings, one of them with every register at zero.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import owbm_pkg::*;

    localparam int STALL_PCT      = 31;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int DIR_ROWS       = 16;
    localparam int DEFAULT_ROWS   = 4;
    localparam int N_SETTINGS     = 3;

    // Mode codes that the block treats as plain ticks.
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    // Slot sequencer phases of the bench's own model.
    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_TAIL,
        SEQ_WR_LOW, SEQ_WR_SLOT, SEQ_WR_REC,
        SEQ_RD_LOW, SEQ_RD_WAIT, SEQ_RD_TAIL
    } t_seq;

    // Where the sampled line level comes from while a command runs.
    typedef enum logic [1:0] {
        LINE_LO,    // held low throughout
        LINE_HI,    // released and pulled up throughout
        LINE_RAND,  // random level on every tick
        LINE_DEV    // a device that answers with a presence pulse only
    } t_line_src;

    // One command of stimulus, with its done-tick result where it is known.
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data;
        t_line_src  line;
        logic [2:0] poke;       // command thrown in on the second tick
        logic       typed;
        t_out_item  done_exp;
    } t_cmd_row;

    // Directed commands; the first rows run at the reset timings.
    t_cmd_row dir_rows [DIR_ROWS] = '{
        '{MODE_TICK,    8'h00, LINE_LO,   MODE_TICK,    1'b1,
          '{DRV_REL,  1'b0, 1'b0, 8'h00, STS_NO_DEVICE}},
        '{MODE_SPARE_6, 8'hFF, LINE_HI,   MODE_TICK,    1'b1,
          '{DRV_REL,  1'b0, 1'b0, 8'h00, STS_NO_DEVICE}},
        '{MODE_SPARE_7, 8'h5A, LINE_LO,   MODE_TICK,    1'b1,
          '{DRV_REL,  1'b0, 1'b0, 8'h00, STS_NO_DEVICE}},
        '{MODE_RD_BIT,  8'h00, LINE_HI,   MODE_TICK,    1'b1,
          '{DRV_REL,  1'b1, 1'b1, 8'h01, STS_NO_DEVICE}},
        '{MODE_RESET,   8'h00, LINE_HI,   MODE_TICK,    1'b1,
          '{DRV_REL,  1'b1, 1'b1, 8'h01, STS_NO_DEVICE}},
        '{MODE_RESET,   8'hFF, LINE_LO,   MODE_TICK,    1'b1,
          '{DRV_REL,  1'b1, 1'b1, 8'h01, STS_STUCK_LOW}},
        '{MODE_RESET,   8'h00, LINE_DEV,  MODE_WR_BYTE, 1'b1,
          '{DRV_REL,  1'b1, 1'b1, 8'h01, STS_PRESENT}},
        '{MODE_WR_BYTE, 8'hFF, LINE_HI,   MODE_TICK,    1'b1,
          '{DRV_HIGH, 1'b1, 1'b1, 8'h01, STS_PRESENT}},
        '{MODE_WR_BYTE, 8'hA5, LINE_RAND, MODE_RD_BYTE, 1'b0, '0},
        '{MODE_WR_BIT,  8'hFE, LINE_HI,   MODE_TICK,    1'b1,
          '{DRV_HIGH, 1'b1, 1'b1, 8'h01, STS_PRESENT}},
        '{MODE_WR_BIT,  8'h01, LINE_RAND, MODE_RESET,   1'b1,
          '{DRV_HIGH, 1'b1, 1'b1, 8'h01, STS_PRESENT}},
        '{MODE_RD_BYTE, 8'h00, LINE_HI,   MODE_TICK,    1'b1,
          '{DRV_REL,  1'b1, 1'b1, 8'hFF, STS_PRESENT}},
        '{MODE_RD_BYTE, 8'hFF, LINE_LO,   MODE_WR_BIT,  1'b1,
          '{DRV_REL,  1'b1, 1'b1, 8'h00, STS_PRESENT}},
        '{MODE_RD_BIT,  8'hFF, LINE_LO,   MODE_RD_BIT,  1'b1,
          '{DRV_REL,  1'b1, 1'b1, 8'h00, STS_PRESENT}},
        '{MODE_TICK,    8'hFF, LINE_HI,   MODE_TICK,    1'b1,
          '{DRV_REL,  1'b0, 1'b0, 8'h00, STS_PRESENT}},
        '{MODE_RESET,   8'h81, LINE_RAND, MODE_RESET,   1'b0, '0}
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_PORT_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data  = '0;
    logic                  o_cfg_ready;
    logic                  i_push      = 1'b0;
    t_in_item              i_in        = '0;
    logic                  o_full;
    logic                  i_pop       = 1'b0;
    logic                  o_empty;
    t_out_item             o_out;

    // Bench bookkeeping.
    t_out_item tick_results_q [$];
    logic      steady       = 1'b0;
    int        mismatches   = 0;
    int        n_checked    = 0;
    int        n_cfg_writes = 0;
    int        quiet_cycles = 0;
    int        cmd_count [8];

    // Model of the sequencer: timings, phase and the held results.
    logic [CFG_W-1:0] timing_q [CFG_NUM] = CFG_RESET_VAL;
    t_seq             bus_seq      = SEQ_IDLE;
    logic [CFG_W-1:0] slot_left    = '0;
    logic [2:0]       bit_pos      = 3'd0;
    logic [7:0]       shift_reg    = 8'h00;
    logic             byte_mode    = 1'b0;
    logic             presence_bit = 1'b1;
    logic [1:0]       status_q     = STS_NO_DEVICE;
    logic [7:0]       read_q       = 8'h00;

    one_wire_bus_master u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out       (o_out)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Length of a phase in ticks; a zero setting still lasts one tick.
    function automatic logic [CFG_W-1:0] slot_len(input t_seq s);
        logic [CFG_W-1:0] d;
        case (s)
            SEQ_RST_LOW:  d = timing_q[CFG_RESET_LOW];
            SEQ_RST_WAIT: d = timing_q[CFG_PRESENCE_WAIT];
            SEQ_RST_TAIL: d = timing_q[CFG_RESET_TAIL];
            SEQ_WR_LOW:   d = timing_q[CFG_WRITE_LOW];
            SEQ_WR_SLOT:  d = timing_q[CFG_WRITE_SLOT];
            SEQ_WR_REC:   d = CFG_W'(RECOVERY_TICKS);
            SEQ_RD_LOW:   d = timing_q[CFG_READ_LOW];
            SEQ_RD_WAIT:  d = timing_q[CFG_READ_WAIT];
            default:      d = timing_q[CFG_READ_TAIL];
        endcase
        if (d == '0) begin
            d = CFG_W'(1);
        end
        return d;
    endfunction

    function automatic void enter_seq(input t_seq s);
        bus_seq   = s;
        slot_left = slot_len(s) - CFG_W'(1);
    endfunction

    function automatic logic [1:0] drive_for(input t_seq s);
        case (s)
            SEQ_RST_LOW, SEQ_WR_LOW, SEQ_RD_LOW: return DRV_LOW;
            SEQ_WR_SLOT: return shift_reg[0] ? DRV_REL : DRV_LOW;
            SEQ_WR_REC:  return DRV_HIGH;
            default:     return DRV_REL;
        endcase
    endfunction

    // End of a bit slot: start the next bit of a byte, or finish.
    function automatic logic bit_finished(input t_seq first_seq);
        if (byte_mode && bit_pos != 3'd7) begin
            bit_pos = bit_pos + 3'd1;
            enter_seq(first_seq);
            return 1'b0;
        end
        bus_seq   = SEQ_IDLE;
        slot_left = '0;
        return 1'b1;
    endfunction

    // Advance the model by one tick and return the result beat it gives.
    function automatic t_out_item next_tick_result(input t_in_item it);
        t_out_item r;
        r = '0;
        r.line_drive = DRV_REL;
        if (bus_seq == SEQ_IDLE && it.mode >= MODE_RESET && it.mode <= MODE_RD_BIT) begin
            bit_pos   = 3'd0;
            byte_mode = (it.mode == MODE_WR_BYTE || it.mode == MODE_RD_BYTE);
            shift_reg = (it.mode == MODE_WR_BIT) ? {7'd0, it.data_byte[0]} : it.data_byte;
            case (it.mode)
                MODE_RESET:               enter_seq(SEQ_RST_LOW);
                MODE_WR_BYTE, MODE_WR_BIT: enter_seq(SEQ_WR_LOW);
                default: begin
                    shift_reg = 8'h00;
                    enter_seq(SEQ_RD_LOW);
                end
            endcase
        end
        if (bus_seq != SEQ_IDLE) begin
            r.busy_res   = 1'b1;
            r.line_drive = drive_for(bus_seq);
            if (slot_left != '0) begin
                slot_left = slot_left - CFG_W'(1);
            end else begin
                case (bus_seq)
                    SEQ_RST_LOW: enter_seq(SEQ_RST_WAIT);
                    SEQ_RST_WAIT: begin
                        presence_bit = it.line_in;
                        enter_seq(SEQ_RST_TAIL);
                    end
                    SEQ_RST_TAIL: begin
                        status_q   = it.line_in ? {1'b0, presence_bit} : STS_STUCK_LOW;
                        bus_seq    = SEQ_IDLE;
                        r.done_res = 1'b1;
                    end
                    SEQ_WR_LOW:  enter_seq(SEQ_WR_SLOT);
                    SEQ_WR_SLOT: enter_seq(SEQ_WR_REC);
                    SEQ_WR_REC: begin
                        shift_reg  = shift_reg >> 1;
                        r.done_res = bit_finished(SEQ_WR_LOW);
                    end
                    SEQ_RD_LOW: enter_seq(SEQ_RD_WAIT);
                    SEQ_RD_WAIT: begin
                        // Bytes fill from the top so that bit 0 ends up first.
                        shift_reg = byte_mode ? {it.line_in, shift_reg[7:1]}
                                              : {7'd0, it.line_in};
                        enter_seq(SEQ_RD_TAIL);
                    end
                    default: begin
                        if (bit_finished(SEQ_RD_LOW)) begin
                            read_q     = shift_reg;
                            r.done_res = 1'b1;
                        end
                    end
                endcase
            end
        end
        r.read_data    = read_q;
        r.reset_status = status_q;
        return r;
    endfunction

    function automatic logic line_level(input t_line_src src);
        case (src)
            LINE_LO:   return 1'b0;
            LINE_HI:   return 1'b1;
            LINE_RAND: return 1'($urandom);
            default:   return (bus_seq == SEQ_RST_WAIT) ? 1'b0 : 1'b1;
        endcase
    endfunction

    // Push one tick beat, idling first at random; returns at a falling edge.
    task automatic push_tick(input t_in_item it, input logic typed, input t_out_item typed_exp);
        t_out_item want;
        while (!steady && $urandom_range(99) < STALL_PCT) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_in   <= it;
        @(posedge i_clk);
        while (o_full) begin
            @(posedge i_clk);
        end
        want = next_tick_result(it);
        // A typed-in row fixes the beat on its last tick.
        if (typed && (want.done_res || !want.busy_res)) begin
            want = typed_exp;
        end
        tick_results_q.push_back(want);
        @(negedge i_clk);
    endtask

    // Issue one command and keep ticking until the model is idle again.
    task automatic run_command(input t_cmd_row row, input logic noisy);
        t_in_item it;
        logic     first_tick;
        it.mode      = row.mode;
        it.data_byte = row.data;
        it.line_in   = line_level(row.line);
        push_tick(it, row.typed, row.done_exp);
        first_tick = 1'b1;
        while (bus_seq != SEQ_IDLE) begin
            if (first_tick) begin
                it.mode = row.poke;
            end else if (noisy && $urandom_range(99) < 8) begin
                it.mode = 3'($urandom_range(7));
            end else begin
                it.mode = MODE_TICK;
            end
            it.data_byte = 8'($urandom);
            it.line_in   = line_level(row.line);
            push_tick(it, row.typed, row.done_exp);
            first_tick = 1'b0;
        end
        cmd_count[row.mode] = cmd_count[row.mode] + 1;
    endtask

    // Random commands with random content, mixed with plain and spare ticks.
    task automatic run_random(input int n_cmds);
        t_cmd_row row;
        int       issued;
        issued = 0;
        while (issued < n_cmds) begin
            row = '0;
            if ($urandom_range(99) < 85) begin
                row.mode = 3'($urandom_range(MODE_RESET, MODE_RD_BIT));
                issued++;
            end else if ($urandom_range(2) == 0) begin
                row.mode = MODE_TICK;
            end else begin
                row.mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
            end
            row.data = 8'($urandom);
            row.line = t_line_src'($urandom_range(3));
            row.poke = ($urandom_range(99) < 20) ? 3'($urandom_range(7)) : MODE_TICK;
            run_command(row, 1'b1);
        end
    endtask

    // Hold the sender until every expected beat is back, then let it settle.
    task automatic settle();
        i_push <= 1'b0;
        while (tick_results_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write all timing registers, and optionally one index past the last.
    task automatic apply_timing(input logic [CFG_W-1:0] vals [CFG_NUM], input logic stray);
        int                    r;
        int                    n_writes;
        logic [CFG_PORT_W-1:0] idx;
        logic [CFG_W-1:0]      dat;
        settle();
        n_writes = stray ? CFG_NUM + 1 : CFG_NUM;
        for (r = 0; r < n_writes; r++) begin
            idx = (r == CFG_NUM) ? CFG_PORT_W'($urandom_range(CFG_NUM, 15)) : CFG_PORT_W'(r);
            dat = (r == CFG_NUM) ? CFG_W'($urandom) : vals[r];
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= dat;
            @(posedge i_clk);
            while (!o_cfg_ready) begin
                @(posedge i_clk);
            end
            if (idx < CFG_NUM) begin
                timing_q[idx[CFG_IDX_W-1:0]] = dat;
            end
            n_cfg_writes++;
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // The receiver stalls at random, except during the steady stretch.
    always @(negedge i_clk) begin
        i_pop <= steady || ($urandom_range(99) >= STALL_PCT);
    end

    // Compare each popped result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (tick_results_q.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, got %p", $time, o_out);
                mismatches++;
            end else begin
                want = tick_results_q.pop_front();
                check_field("line_drive",   8'(want.line_drive),   8'(o_out.line_drive));
                check_field("busy_res",     8'(want.busy_res),     8'(o_out.busy_res));
                check_field("done_res",     8'(want.done_res),     8'(o_out.done_res));
                check_field("read_data",    want.read_data,        o_out.read_data);
                check_field("reset_status", 8'(want.reset_status), 8'(o_out.reset_status));
                n_checked++;
            end
        end
    end

    // Watchdog: a correct run moves a beat almost every cycle, so a long
    // quiet spell means the block has hung.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then the timing settings.
    initial begin
        logic [CFG_W-1:0] vals [CFG_NUM];
        int               s;
        int               r;
        int               n_cmds;
        for (r = 0; r < 8; r++) begin
            cmd_count[r] = 0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Plain ticks and a bit read at the reset timings.
        for (r = 0; r < DEFAULT_ROWS; r++) begin
            run_command(dir_rows[r], 1'b0);
        end

        // The rest of the table at the shortest slots.
        for (r = 0; r < CFG_NUM; r++) begin
            vals[r] = CFG_W'(1);
        end
        apply_timing(vals, 1'b1);
        for (r = DEFAULT_ROWS; r < DIR_ROWS; r++) begin
            run_command(dir_rows[r], 1'b0);
        end

        for (s = 0; s < N_SETTINGS; s++) begin
            for (r = 0; r < CFG_NUM; r++) begin
                if (s == 0) begin
                    vals[r] = '0;
                end else begin
                    vals[r] = ($urandom_range(99) < 10) ? '0 : CFG_W'($urandom_range(1, 6));
                end
            end
            n_cmds = (s == 0) ? 4 : ((s == 1) ? 2 : 3);
            apply_timing(vals, 1'($urandom));
            steady = (s == 2);
            run_random(n_cmds);
        end

        steady = 1'b0;
        settle();
        $display("Covered %0d resets, %0d byte writes, %0d byte reads,",
                 cmd_count[MODE_RESET], cmd_count[MODE_WR_BYTE], cmd_count[MODE_RD_BYTE]);
        $display("%0d bit writes and %0d bit reads over %0d timing settings;",
                 cmd_count[MODE_WR_BIT], cmd_count[MODE_RD_BIT], N_SETTINGS + 2);
        $display("%0d register writes, %0d tick beats checked.", n_cfg_writes, n_checked);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
